// ===== rtl/tdfc_pkg.sv =====
// Touch dimmer fade controller: shared widths, constants, codes and types.
// No dependencies; every other file takes its names from here by scope.
`default_nettype none

package tdfc_pkg;

   localparam int TIME_BITS  = 16;
   localparam int NOW_W      = 16;
   localparam int SAMPLE_W   = 10;
   localparam int HOLD_CFG_W = 16;
   localparam int LEVEL_W    = 8;
   localparam int PHASE_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCOUNT_W = $clog2(QDEPTH + 1);

   localparam int FADE_MS       = 1000;
   localparam int RAMP_DELAY_MS = 1000;
   localparam int RAMP_MS       = 7000;
   localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;

   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_BELOW   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_ABOVE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SETUP_HOLD    = 2'd2;

   localparam logic [SAMPLE_W-1:0]   PRESS_BELOW_RST   = 10'd500;
   localparam logic [SAMPLE_W-1:0]   RELEASE_ABOVE_RST = 10'd600;
   localparam logic [HOLD_CFG_W-1:0] SETUP_HOLD_RST    = 16'd1000;

   // fade: elapsed clamped to FADE_MS times level, then divided by FADE_MS
   localparam int FADE_E_W     = 10;
   localparam int FADE_PROD_W  = FADE_E_W + LEVEL_W;
   localparam int FADE_SHIFT   = 28;
   localparam int FADE_RECIP_W = 19;
   localparam logic [FADE_RECIP_W-1:0] FADE_RECIP =
      FADE_RECIP_W'(((64'd1 << FADE_SHIFT) + 64'(FADE_MS) - 64'd1) / 64'(FADE_MS));
   localparam int FADE_MUL_W = FADE_PROD_W + FADE_RECIP_W;

   // ramp: offset up to RAMP_MS times 255, then divided by RAMP_MS
   localparam int RAMP_X_W     = 13;
   localparam int RAMP_NUM_W   = RAMP_X_W + LEVEL_W;
   localparam int RAMP_SHIFT   = 34;
   localparam int RAMP_RECIP_W = 22;
   localparam logic [RAMP_RECIP_W-1:0] RAMP_RECIP =
      RAMP_RECIP_W'(((64'd1 << RAMP_SHIFT) + 64'(RAMP_MS) - 64'd1) / 64'(RAMP_MS));
   localparam int RAMP_MUL_W = RAMP_NUM_W + RAMP_RECIP_W;

   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE  = 2'd0,
      PH_FADE  = 2'd1,
      PH_SETUP = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      DUTY_HOLD = 2'd0,
      DUTY_FADE = 2'd1,
      DUTY_SET  = 2'd2
   } duty_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] now;
      logic [TIME_BITS-1:0] elapsed;
   } hold_type;

   typedef struct packed {
      duty_type                 kind;
      logic [LEVEL_W-1:0]       level;
      logic [FADE_PROD_W-1:0]   prod;
      logic [LEVEL_W-1:0]       max;
      logic                     light;
      phase_type                phase;
   } step_type;

endpackage

`default_nettype wire

// ===== rtl/tdfc_if.sv =====
// Channel interfaces of the touch dimmer fade controller: sample, result, register write.
// Depends on tdfc_pkg for field widths.
`default_nettype none

interface tdfc_req_if;
   logic                          valid;
   logic                          ready;
   logic [tdfc_pkg::SAMPLE_W-1:0] sensor_sample;
   logic [tdfc_pkg::NOW_W-1:0]    now_ms;
   modport source (output valid, sensor_sample, now_ms, input ready);
   modport sink   (input valid, sensor_sample, now_ms, output ready);
endinterface

interface tdfc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tdfc_pkg::LEVEL_W-1:0] pwm_level;
   logic                         lights_on;
   logic [tdfc_pkg::PHASE_W-1:0] phase;
   modport source (output valid, pwm_level, lights_on, phase, input ready);
   modport sink   (input valid, pwm_level, lights_on, phase, output ready);
endinterface

interface tdfc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tdfc_pkg::CSR_IDX_W-1:0]  index;
   logic [tdfc_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tdfc_front.sv =====
// Front end: accepts sensor beats, qualifies the touch and tracks hold time.
// Depends on tdfc_pkg and tdfc_req_if; feeds tdfc_queue.
`default_nettype none

module tdfc_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   tdfc_req_if.sink                           req_bus,
   input  wire logic [tdfc_pkg::SAMPLE_W-1:0] press_below,
   input  wire logic [tdfc_pkg::SAMPLE_W-1:0] release_above,
   input  wire logic                          queue_full,
   output logic                               push,
   output tdfc_pkg::hold_type                 entry
);

   logic [tdfc_pkg::TIME_BITS-1:0] hold_start_ff, hold_start_in;
   logic [tdfc_pkg::TIME_BITS-1:0] hold_elapsed_ff, hold_elapsed_in;
   logic [tdfc_pkg::TIME_BITS-1:0] now_t;
   logic                           touched;
   logic                           released;

   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && req_bus.ready;
   assign now_t         = tdfc_pkg::TIME_BITS'(req_bus.now_ms);
   assign touched       = req_bus.sensor_sample < press_below;
   assign released      = req_bus.sensor_sample > release_above;

   always_comb begin
      hold_start_in   = hold_start_ff;
      hold_elapsed_in = hold_elapsed_ff;
      if (touched) begin
         if (hold_start_ff == '0) begin
            hold_start_in = now_t;
         end
         hold_elapsed_in = now_t - hold_start_in;
      end else if (released) begin
         hold_start_in   = '0;
         hold_elapsed_in = '0;
      end
   end

   assign entry.now     = now_t;
   assign entry.elapsed = hold_elapsed_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_start_ff   <= '0;
         hold_elapsed_ff <= '0;
      end else if (push) begin
         hold_start_ff   <= hold_start_in;
         hold_elapsed_ff <= hold_elapsed_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tdfc_queue.sv =====
// Short register queue between the front end and the phase sequencer.
// Depends on tdfc_pkg for the entry type and depth.
`default_nettype none

module tdfc_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tdfc_pkg::hold_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output logic                    not_empty,
   output tdfc_pkg::hold_type      head
);

   tdfc_pkg::hold_type                 mem_ff [tdfc_pkg::QDEPTH];
   logic [tdfc_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [tdfc_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [tdfc_pkg::QCOUNT_W-1:0]      count_ff, count_in;

   assign full      = count_ff == tdfc_pkg::QCOUNT_W'(tdfc_pkg::QDEPTH);
   assign not_empty = count_ff != '0;
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tdfc_pkg::QPTR_W'(tdfc_pkg::QDEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tdfc_pkg::QPTR_W'(tdfc_pkg::QDEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tdfc_pkg::QCOUNT_W'(tdfc_pkg::QDEPTH))
      else $error("queue count past depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue popped while empty");

endmodule

`default_nettype wire

// ===== rtl/tdfc_phase.sv =====
// Phase sequencer: toggle, fade start, intensity ramp and stored maximum level.
// Depends on tdfc_pkg; pops tdfc_queue and feeds tdfc_level through a step register.
`default_nettype none

module tdfc_phase (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [tdfc_pkg::HOLD_CFG_W-1:0] setup_hold_ms,
   input  wire logic                            q_valid,
   input  wire tdfc_pkg::hold_type              q_entry,
   output logic                                 q_pop,
   input  wire logic                            down_ready,
   output logic                                 step_valid,
   output tdfc_pkg::step_type                   step
);

   localparam int TB = tdfc_pkg::TIME_BITS;

   tdfc_pkg::phase_type           phase_ff, phase_in;
   logic                          light_ff, light_in;
   logic [TB-1:0]                 pstart_ff, pstart_in;
   logic [tdfc_pkg::LEVEL_W-1:0]  max_ff, max_in;
   logic [tdfc_pkg::LEVEL_W-1:0]  setup_lvl_ff, setup_lvl_in;
   logic                          step_valid_ff;
   tdfc_pkg::step_type            step_ff, step_in;
   logic                          advance;
   logic                          fire;

   assign advance    = !step_valid_ff || down_ready;
   assign fire       = q_valid && advance;
   assign q_pop      = fire;
   assign step_valid = step_valid_ff;
   assign step       = step_ff;

   always_comb begin
      logic [TB-1:0]                     he;
      logic [TB-1:0]                     e;
      logic [TB-1:0]                     x;
      logic [TB:0]                       limit;
      logic [tdfc_pkg::FADE_E_W-1:0]     ec;
      logic [tdfc_pkg::RAMP_NUM_W-1:0]   n;
      logic [tdfc_pkg::RAMP_MUL_W-1:0]   rp;
      logic [tdfc_pkg::LEVEL_W-1:0]      ramp_v;
      logic [tdfc_pkg::LEVEL_W-1:0]      lvl;
      tdfc_pkg::duty_type                kind;

      phase_in     = phase_ff;
      light_in     = light_ff;
      pstart_in    = pstart_ff;
      max_in       = max_ff;
      setup_lvl_in = setup_lvl_ff;
      he           = q_entry.elapsed;
      kind         = tdfc_pkg::DUTY_HOLD;
      lvl          = '0;

      if (he != '0 && phase_in == tdfc_pkg::PH_IDLE) begin
         pstart_in = q_entry.now;
         light_in  = !light_in;
         phase_in  = tdfc_pkg::PH_FADE;
      end

      if (he == '0 && phase_in == tdfc_pkg::PH_SETUP) begin
         phase_in = tdfc_pkg::PH_IDLE;
         if (setup_lvl_in != '0) begin
            max_in = setup_lvl_in;
         end
         light_in = 1'b1;
      end

      limit = (TB + 1)'(setup_hold_ms) + (TB + 1)'(tdfc_pkg::RAMP_MS);
      if (TB'(setup_hold_ms) < he && {1'b0, he} < limit &&
          phase_in != tdfc_pkg::PH_SETUP) begin
         pstart_in = q_entry.now;
         phase_in  = tdfc_pkg::PH_SETUP;
      end

      e = q_entry.now - pstart_in;

      ec = (e >= TB'(tdfc_pkg::FADE_MS)) ? tdfc_pkg::FADE_E_W'(tdfc_pkg::FADE_MS) :
           e[tdfc_pkg::FADE_E_W-1:0];

      x = (e >= TB'(tdfc_pkg::RAMP_DELAY_MS)) ? e - TB'(tdfc_pkg::RAMP_DELAY_MS) : '0;
      n = {x[tdfc_pkg::RAMP_X_W-1:0], tdfc_pkg::LEVEL_W'(0)} -
          tdfc_pkg::RAMP_NUM_W'(x[tdfc_pkg::RAMP_X_W-1:0]);
      rp = tdfc_pkg::RAMP_MUL_W'(n) * tdfc_pkg::RAMP_MUL_W'(tdfc_pkg::RAMP_RECIP);
      if (x > TB'(tdfc_pkg::RAMP_MS)) begin
         ramp_v = tdfc_pkg::FULL_LEVEL;
      end else begin
         ramp_v = rp[tdfc_pkg::RAMP_SHIFT +: tdfc_pkg::LEVEL_W];
      end

      case (phase_in)
         tdfc_pkg::PH_FADE: begin
            kind = tdfc_pkg::DUTY_FADE;
            if (e > TB'(tdfc_pkg::FADE_MS)) begin
               phase_in = tdfc_pkg::PH_IDLE;
            end
         end
         tdfc_pkg::PH_SETUP: begin
            setup_lvl_in = ramp_v;
            kind         = tdfc_pkg::DUTY_SET;
            lvl          = ramp_v;
            if (e > TB'(tdfc_pkg::RAMP_MS + tdfc_pkg::RAMP_DELAY_MS)) begin
               max_in   = tdfc_pkg::FULL_LEVEL;
               lvl      = tdfc_pkg::FULL_LEVEL;
               phase_in = tdfc_pkg::PH_IDLE;
            end
         end
         default: begin
            kind = tdfc_pkg::DUTY_HOLD;
         end
      endcase

      step_in.kind  = kind;
      step_in.level = lvl;
      step_in.prod  = tdfc_pkg::FADE_PROD_W'(ec) * tdfc_pkg::FADE_PROD_W'(max_in);
      step_in.max   = max_in;
      step_in.light = light_in;
      step_in.phase = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= tdfc_pkg::PH_IDLE;
         light_ff      <= 1'b0;
         pstart_ff     <= '0;
         max_ff        <= tdfc_pkg::FULL_LEVEL;
         setup_lvl_ff  <= '0;
         step_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff     <= phase_in;
            light_ff     <= light_in;
            pstart_ff    <= pstart_in;
            max_ff       <= max_in;
            setup_lvl_ff <= setup_lvl_in;
         end
         if (advance) begin
            step_valid_ff <= fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         step_ff <= step_in;
      end
   end

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(phase_ff) && $stable(light_ff) && $stable(max_ff))
      else $error("phase state moved without a step");

   a_step_matches: assert property (@(posedge clock) disable iff (reset)
      fire |=> step_ff.phase == phase_ff && step_ff.light == light_ff &&
               step_ff.max == max_ff)
      else $error("step register out of line with phase state");

endmodule

`default_nettype wire

// ===== rtl/tdfc_level.sv =====
// Level stage: fade scaling, duty hold and the result output register.
// Depends on tdfc_pkg and tdfc_rsp_if; takes steps from tdfc_phase.
`default_nettype none

module tdfc_level (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step_valid,
   input  wire tdfc_pkg::step_type step,
   output logic                    up_ready,
   tdfc_rsp_if.source              rsp_bus
);

   logic                                rsp_valid_ff;
   logic [tdfc_pkg::LEVEL_W-1:0]        duty_ff, duty_in;
   logic                                light_ff;
   logic [tdfc_pkg::PHASE_W-1:0]        phase_ff;
   logic [tdfc_pkg::FADE_MUL_W-1:0]     fade_mul;
   logic [tdfc_pkg::LEVEL_W-1:0]        fade_q;
   logic [tdfc_pkg::LEVEL_W-1:0]        fade_v;
   logic                                advance;
   logic                                take;

   assign advance  = !rsp_valid_ff || rsp_bus.ready;
   assign take     = step_valid && advance;
   assign up_ready = advance;

   assign fade_mul = tdfc_pkg::FADE_MUL_W'(step.prod) *
                     tdfc_pkg::FADE_MUL_W'(tdfc_pkg::FADE_RECIP);
   assign fade_q   = fade_mul[tdfc_pkg::FADE_SHIFT +: tdfc_pkg::LEVEL_W];
   assign fade_v   = step.light ? fade_q : step.max - fade_q;

   always_comb begin
      case (step.kind)
         tdfc_pkg::DUTY_HOLD: duty_in = duty_ff;
         tdfc_pkg::DUTY_FADE: duty_in = fade_v;
         tdfc_pkg::DUTY_SET:  duty_in = step.level;
         default:             duty_in = duty_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         duty_ff      <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= step_valid;
         end
         if (take) begin
            duty_ff <= duty_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         light_ff <= step.light;
         phase_ff <= step.phase;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.pwm_level = duty_ff;
   assign rsp_bus.lights_on = light_ff;
   assign rsp_bus.phase     = phase_ff;

endmodule

`default_nettype wire

// ===== rtl/touch_dimmer_fade_controller_unit.sv =====
// Touch dimmer fade controller top level: register file and the front/queue/back chain.
// Depends on tdfc_pkg, tdfc_if, tdfc_front, tdfc_queue, tdfc_phase and tdfc_level.
//
// Usage:
//   req_bus carries one beat per sensor sample: sensor_sample and now_ms.
//   rsp_bus returns exactly one beat per sample: pwm_level, lights_on, phase.
//   csr_bus writes press_below (0), release_above (1) and setup_hold_ms (2);
//   it is always ready, and other indexes are dropped. Write only while idle.
// Timing:
//   An accepted sample is registered in the queue, then in the phase sequencer step
//   register, then in the level stage output register, which drives the result.
//   One sample per cycle sustained while rsp_bus.ready stays high; the fade and ramp
//   divisions are reciprocal multiplies, one per stage, so nothing iterates.
// Reset (synchronous): registers return to 500 / 600 / 1000, light off, idle,
//   duty 0, stored maximum 255, queue empty. No clearing pass.
// Stall: when rsp_bus.ready is low the output and step registers hold, the
//   two-entry queue absorbs up to two more samples, then req_bus.ready drops.
`default_nettype none

module touch_dimmer_fade_controller_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   tdfc_req_if.sink   req_bus,
   tdfc_rsp_if.source rsp_bus,
   tdfc_csr_if.sink   csr_bus
);

   logic [tdfc_pkg::SAMPLE_W-1:0]   press_below_ff;
   logic [tdfc_pkg::SAMPLE_W-1:0]   release_above_ff;
   logic [tdfc_pkg::HOLD_CFG_W-1:0] setup_hold_ff;

   logic                 push;
   tdfc_pkg::hold_type   push_entry;
   logic                 q_full;
   logic                 q_pop;
   logic                 q_valid;
   tdfc_pkg::hold_type   q_head;
   logic                 step_valid;
   tdfc_pkg::step_type   step;
   logic                 level_ready;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         press_below_ff   <= tdfc_pkg::PRESS_BELOW_RST;
         release_above_ff <= tdfc_pkg::RELEASE_ABOVE_RST;
         setup_hold_ff    <= tdfc_pkg::SETUP_HOLD_RST;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            tdfc_pkg::CSR_PRESS_BELOW:
               press_below_ff <= csr_bus.data[tdfc_pkg::SAMPLE_W-1:0];
            tdfc_pkg::CSR_RELEASE_ABOVE:
               release_above_ff <= csr_bus.data[tdfc_pkg::SAMPLE_W-1:0];
            tdfc_pkg::CSR_SETUP_HOLD:
               setup_hold_ff <= csr_bus.data[tdfc_pkg::HOLD_CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   tdfc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .press_below   (press_below_ff),
      .release_above (release_above_ff),
      .queue_full    (q_full),
      .push          (push),
      .entry         (push_entry)
   );

   tdfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head      (q_head)
   );

   tdfc_phase u_phase (
      .clock         (clock),
      .reset         (reset),
      .setup_hold_ms (setup_hold_ff),
      .q_valid       (q_valid),
      .q_entry       (q_head),
      .q_pop         (q_pop),
      .down_ready    (level_ready),
      .step_valid    (step_valid),
      .step          (step)
   );

   tdfc_level u_level (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_valid),
      .step       (step),
      .up_ready   (level_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for touch_dimmer_fade_controller_unit: a directed sample table, then random
// press / hold / release episodes under several register settings, all beats scored in-bench.
// Depends on tdfc_pkg, the tdfc channel interfaces and the unit's RTL.

module testbench;

   localparam logic [tdfc_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int QUIET_LIMIT     = 3000;
   localparam int HOLD_OFF_CYCLES = 64;

   typedef enum int {BAND_TOUCH, BAND_MID, BAND_FREE} band_type;

   typedef struct packed {
      logic [tdfc_pkg::LEVEL_W-1:0] pwm;
      logic                         lit;
      tdfc_pkg::phase_type          ph;
   } lamp_type;

   typedef struct {
      logic [tdfc_pkg::SAMPLE_W-1:0] s;
      logic [tdfc_pkg::NOW_W-1:0]    t;
      bit                            typed;
      lamp_type                      out;
   } plan_row_type;

   logic clock;
   logic reset;

   tdfc_req_if req_bus ();
   tdfc_rsp_if rsp_bus ();
   tdfc_csr_if csr_bus ();

   touch_dimmer_fade_controller_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   logic [tdfc_pkg::SAMPLE_W-1:0]   thr_press   = tdfc_pkg::PRESS_BELOW_RST;
   logic [tdfc_pkg::SAMPLE_W-1:0]   thr_release = tdfc_pkg::RELEASE_ABOVE_RST;
   logic [tdfc_pkg::HOLD_CFG_W-1:0] setup_ms    = tdfc_pkg::SETUP_HOLD_RST;
   logic [tdfc_pkg::TIME_BITS-1:0]  hold_t0     = '0;
   logic [tdfc_pkg::TIME_BITS-1:0]  hold_ms     = '0;
   logic [tdfc_pkg::TIME_BITS-1:0]  ph_t0       = '0;
   tdfc_pkg::phase_type             ph_now      = tdfc_pkg::PH_IDLE;
   logic                            lit         = 1'b0;
   logic [tdfc_pkg::LEVEL_W-1:0]    top_lvl     = tdfc_pkg::FULL_LEVEL;
   logic [tdfc_pkg::LEVEL_W-1:0]    ramp_lvl    = '0;
   logic [tdfc_pkg::LEVEL_W-1:0]    duty        = '0;

   lamp_type                   lamp_due[$];
   plan_row_type               plan[25];
   logic [tdfc_pkg::NOW_W-1:0] wall_ms = '0;
   int                         sender_idle_pct = 0;
   int                         rsp_stall_pct   = 0;
   bit                         hold_request    = 1'b0;
   int                         sent_total      = 0;
   int                         checked_total   = 0;
   int                         writes_total    = 0;
   int                         mismatches      = 0;

   function automatic lamp_type advance_dimmer(input logic [tdfc_pkg::SAMPLE_W-1:0] s,
                                               input logic [tdfc_pkg::NOW_W-1:0] t);
      logic [tdfc_pkg::TIME_BITS-1:0] span;
      int unsigned                    lvl;
      if (s < thr_press) begin
         if (hold_t0 == '0) hold_t0 = t;
         hold_ms = t - hold_t0;
      end else if (s > thr_release) begin
         hold_t0 = '0;
         hold_ms = '0;
      end
      if (hold_ms != '0 && ph_now == tdfc_pkg::PH_IDLE) begin
         ph_t0  = t;
         lit    = ~lit;
         ph_now = tdfc_pkg::PH_FADE;
      end
      if (hold_ms == '0 && ph_now == tdfc_pkg::PH_SETUP) begin
         ph_now = tdfc_pkg::PH_IDLE;
         if (ramp_lvl != '0) top_lvl = ramp_lvl;
         lit = 1'b1;
      end
      if (int'(setup_ms) < int'(hold_ms) &&
          int'(hold_ms) < int'(setup_ms) + tdfc_pkg::RAMP_MS &&
          ph_now != tdfc_pkg::PH_SETUP) begin
         ph_t0  = t;
         ph_now = tdfc_pkg::PH_SETUP;
      end
      if (ph_now == tdfc_pkg::PH_FADE) begin
         span = t - ph_t0;
         lvl  = int'(span) * int'(top_lvl) / tdfc_pkg::FADE_MS;
         if (lvl > top_lvl) lvl = top_lvl;
         if (!lit) lvl = top_lvl - lvl;
         duty = tdfc_pkg::LEVEL_W'(lvl);
         if (span > tdfc_pkg::FADE_MS) ph_now = tdfc_pkg::PH_IDLE;
      end
      if (ph_now == tdfc_pkg::PH_SETUP) begin
         span = t - ph_t0;
         lvl  = 0;
         if (span >= tdfc_pkg::RAMP_DELAY_MS) begin
            lvl = (int'(span) - tdfc_pkg::RAMP_DELAY_MS) * int'(tdfc_pkg::FULL_LEVEL) /
                  tdfc_pkg::RAMP_MS;
            if (lvl > tdfc_pkg::FULL_LEVEL) lvl = tdfc_pkg::FULL_LEVEL;
         end
         ramp_lvl = tdfc_pkg::LEVEL_W'(lvl);
         duty     = tdfc_pkg::LEVEL_W'(lvl);
         if (span > tdfc_pkg::RAMP_MS + tdfc_pkg::RAMP_DELAY_MS) begin
            top_lvl = tdfc_pkg::FULL_LEVEL;
            duty    = tdfc_pkg::FULL_LEVEL;
            ph_now  = tdfc_pkg::PH_IDLE;
         end
      end
      return '{pwm: duty, lit: lit, ph: ph_now};
   endfunction

   task automatic push_sample(input logic [tdfc_pkg::SAMPLE_W-1:0] s,
                              input logic [tdfc_pkg::NOW_W-1:0] t,
                              input bit typed, input lamp_type typed_out);
      lamp_type predicted;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.sensor_sample <= s;
      req_bus.now_ms        <= t;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = advance_dimmer(s, t);
      lamp_due.push_back(typed ? typed_out : predicted);
      sent_total++;
   endtask

   task automatic emit(input band_type b, input int dt);
      logic [tdfc_pkg::SAMPLE_W-1:0] s;
      wall_ms += tdfc_pkg::NOW_W'(dt);
      case (b)
         BAND_TOUCH: begin
            s = (thr_press == '0) ? tdfc_pkg::SAMPLE_W'($urandom)
                : tdfc_pkg::SAMPLE_W'($urandom_range(0, thr_press - 1'b1));
         end
         BAND_MID: begin
            s = (thr_press <= thr_release)
                ? tdfc_pkg::SAMPLE_W'($urandom_range(thr_press, thr_release))
                : tdfc_pkg::SAMPLE_W'($urandom);
         end
         default: begin
            s = (thr_release == '1) ? tdfc_pkg::SAMPLE_W'($urandom)
                : tdfc_pkg::SAMPLE_W'($urandom_range(thr_release + 1'b1, 1023));
         end
      endcase
      push_sample(s, wall_ms, 1'b0, '0);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (lamp_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [tdfc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tdfc_pkg::CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         tdfc_pkg::CSR_PRESS_BELOW:   thr_press   = value[tdfc_pkg::SAMPLE_W-1:0];
         tdfc_pkg::CSR_RELEASE_ABOVE: thr_release = value[tdfc_pkg::SAMPLE_W-1:0];
         tdfc_pkg::CSR_SETUP_HOLD:    setup_ms    = value[tdfc_pkg::HOLD_CFG_W-1:0];
         default: ;
      endcase
      writes_total++;
   endtask

   task automatic set_regs(input logic [tdfc_pkg::CSR_DATA_W-1:0] press,
                           input logic [tdfc_pkg::CSR_DATA_W-1:0] rel,
                           input logic [tdfc_pkg::CSR_DATA_W-1:0] hold);
      drain();
      write_reg(tdfc_pkg::CSR_PRESS_BELOW, press);
      write_reg(tdfc_pkg::CSR_RELEASE_ABOVE, rel);
      write_reg(tdfc_pkg::CSR_SETUP_HOLD, hold);
      write_reg(CSR_UNUSED, tdfc_pkg::CSR_DATA_W'($urandom));
      csr_bus.valid <= 1'b0;
   endtask

   task automatic random_samples(input int n);
      int goal;
      int k;
      int reps;
      int pick;
      int target;
      int held;
      goal = sent_total + n;
      while (sent_total < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            reps = $urandom_range(1, 4);
            for (k = 0; k < reps; k++) emit(BAND_TOUCH, $urandom_range(0, 300));
            reps = $urandom_range(1, 3);
            for (k = 0; k < reps; k++) emit(BAND_FREE, $urandom_range(20, 600));
         end else if (pick < 55) begin
            // long hold: run into the ramp, sometimes past its end
            target = int'(setup_ms) + $urandom_range(200, 9000);
            if (target > 15000) target = $urandom_range(1000, 15000);
            held = 0;
            emit(BAND_TOUCH, $urandom_range(10, 200));
            while (held < target) begin
               k = $urandom_range(80, 500);
               held += k;
               emit(($urandom_range(0, 9) == 0) ? BAND_MID : BAND_TOUCH, k);
            end
            emit(BAND_FREE, $urandom_range(20, 400));
         end else if (pick < 70) begin
            reps = $urandom_range(2, 6);
            for (k = 0; k < reps; k++) begin
               emit(band_type'($urandom_range(0, 2)), $urandom_range(0, 400));
            end
         end else if (pick < 88) begin
            emit(BAND_FREE, $urandom_range(0, 3000));
         end else begin
            if ($urandom_range(0, 1) == 1) wall_ms = tdfc_pkg::NOW_W'($urandom);
            push_sample(tdfc_pkg::SAMPLE_W'($urandom), tdfc_pkg::NOW_W'($urandom), 1'b0, '0);
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side: score each beat, then pick next ready
   initial begin
      int       hold_left;
      lamp_type want;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (lamp_due.size() == 0) begin
               $display("%0t: result beat with nothing pending: pwm_level %0d lights_on %0b",
                        $time, rsp_bus.pwm_level, rsp_bus.lights_on);
               $display("%0t: phase %0d", $time, rsp_bus.phase);
               mismatches++;
            end else begin
               want = lamp_due.pop_front();
               checked_total++;
               if (rsp_bus.pwm_level !== want.pwm) begin
                  $display("%0t: pwm_level expected %0d actual %0d",
                           $time, want.pwm, rsp_bus.pwm_level);
                  mismatches++;
               end
               if (rsp_bus.lights_on !== want.lit) begin
                  $display("%0t: lights_on expected %0b actual %0b",
                           $time, want.lit, rsp_bus.lights_on);
                  mismatches++;
               end
               if (rsp_bus.phase !== want.ph) begin
                  $display("%0t: phase expected %0d actual %0d", $time, want.ph, rsp_bus.phase);
                  mismatches++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
         @(posedge clock);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: watchdog, %0d cycles without a beat", $time, QUIET_LIMIT);
      $display("** touch_dimmer_fade_controller_unit: FAILED **");
      $finish;
   end

   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.sensor_sample <= '0;
      req_bus.now_ms        <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.index         <= '0;
      csr_bus.data          <= '0;
      sender_idle_pct = 25;
      rsp_stall_pct   = 83;
      plan = '{
         '{10'd1023, 16'd0,     1'b1, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd0,    16'd0,     1'b1, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd0,    16'd0,     1'b1, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd0,    16'd10,    1'b1, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd0,    16'd20,    1'b0, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd600,  16'd520,   1'b0, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd1023, 16'd1100,  1'b1, '{8'd255, 1'b1, tdfc_pkg::PH_IDLE}},
         '{10'd1023, 16'd1200,  1'b1, '{8'd255, 1'b1, tdfc_pkg::PH_IDLE}},
         '{10'd499,  16'd2000,  1'b0, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd100,  16'd2500,  1'b0, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd100,  16'd3200,  1'b0, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd100,  16'd7700,  1'b0, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd601,  16'd7800,  1'b0, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd0,    16'd10000, 1'b0, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd0,    16'd10100, 1'b0, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd0,    16'd11200, 1'b0, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd0,    16'd19300, 1'b0, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd0,    16'd19400, 1'b0, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd1023, 16'd20500, 1'b0, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd0,    16'd30000, 1'b0, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd0,    16'd30100, 1'b0, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd0,    16'd31200, 1'b0, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd1023, 16'd31300, 1'b1, '{8'd0,   1'b1, tdfc_pkg::PH_IDLE}},
         '{10'd0,    16'd65535, 1'b0, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}},
         '{10'd0,    16'd100,   1'b0, '{8'd0,   1'b0, tdfc_pkg::PH_IDLE}}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) push_sample(plan[i].s, plan[i].t, plan[i].typed, plan[i].out);
      wall_ms = 16'd200;

      set_regs(16'd400, 16'd700, 16'd1000);
      random_samples(120);

      sender_idle_pct = 83;
      rsp_stall_pct   = 25;
      set_regs(16'hFFFF, 16'h0000, 16'h0000);
      random_samples(80);
      set_regs(16'h0000, 16'hFFFF, 16'hFFFF);
      random_samples(35);

      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      set_regs(16'hF9F4, 16'd600, 16'd300);
      hold_request = 1'b1;
      random_samples(60);
      drain();
      random_samples(60);
      set_regs(16'd250, 16'd900, 16'd6000);
      random_samples(110);

      drain();
      repeat (4) @(posedge clock);
      $display("covered %0d samples under six register settings, with stalls, a hold-off",
               sent_total);
      $display("and a pause; %0d results checked, %0d register writes, %0d mismatches",
               checked_total, writes_total, mismatches);
      if (mismatches == 0) begin
         $display("** touch_dimmer_fade_controller_unit: PASSED **");
      end else begin
         $display("** touch_dimmer_fade_controller_unit: FAILED **");
      end
      $finish;
   end

endmodule
